[hdl/cc2p_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc2p_pkg
// Shared widths, constants and types of the CORDIC Cartesian-to-polar pipeline.
// ----------------------------------------------------------------------------
package cc2p_pkg;

   localparam int COORD_W        = 16;
   localparam int MAG_W          = 16;
   localparam int PHASE_W        = 19;
   // Working x/y width: gain growth from a 16-bit point stays below 2^18.
   localparam int XY_W           = 20;
   // Angle accumulator at 2^-24; its magnitude stays below 2^26.
   localparam int ACC_W          = 28;
   localparam int ATAN_ENTRIES   = 24;
   localparam int DEF_ITERATIONS = 16;

   localparam logic signed [ACC_W-1:0] HALF_PI_Q24 = ACC_W'(26353589);
   localparam int INV_GAIN_W = 16;
   localparam logic [INV_GAIN_W-1:0] INV_GAIN_Q16 = 16'd39797;
   localparam int MAG_PROD_W = (XY_W - 1) + INV_GAIN_W;
   localparam logic [MAG_PROD_W-1:0] MAG_ROUND = MAG_PROD_W'(32768);
   localparam int PH_W = ACC_W + 1;
   localparam logic signed [PH_W-1:0] PHASE_LIMIT = PH_W'(205887);
   localparam logic signed [PH_W-1:0] PHASE_ROUND = PH_W'(128);

   typedef struct packed {
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [ACC_W-1:0] acc;
   } stage_type;

   // round(atan(2^-i) * 2^24)
   function automatic logic signed [ACC_W-1:0] atan_q24(input int idx);
      logic signed [ACC_W-1:0] val;
      case (idx)
         0:       val = ACC_W'(13176795);
         1:       val = ACC_W'(7778716);
         2:       val = ACC_W'(4110060);
         3:       val = ACC_W'(2086331);
         4:       val = ACC_W'(1047214);
         5:       val = ACC_W'(524117);
         6:       val = ACC_W'(262123);
         7:       val = ACC_W'(131069);
         8:       val = ACC_W'(65536);
         9:       val = ACC_W'(32768);
         10:      val = ACC_W'(16384);
         11:      val = ACC_W'(8192);
         12:      val = ACC_W'(4096);
         13:      val = ACC_W'(2048);
         14:      val = ACC_W'(1024);
         15:      val = ACC_W'(512);
         16:      val = ACC_W'(256);
         17:      val = ACC_W'(128);
         18:      val = ACC_W'(64);
         19:      val = ACC_W'(32);
         20:      val = ACC_W'(16);
         21:      val = ACC_W'(8);
         22:      val = ACC_W'(4);
         23:      val = ACC_W'(2);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

[hdl/cc2p_micro_rot.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc2p_micro_rot
// One registered CORDIC vectoring micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
module cc2p_micro_rot #(
   parameter int SHIFT = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  cc2p_pkg::stage_type in_stage,
   output logic                out_valid,
   output cc2p_pkg::stage_type out_stage
);
   import cc2p_pkg::*;

   localparam logic signed [ACC_W-1:0] ATAN_STEP = atan_q24(SHIFT);

   logic signed [XY_W-1:0] dx;
   logic signed [XY_W-1:0] dy;
   stage_type              stage_in;
   stage_type              stage_ff;
   logic                   valid_ff;

   assign dx = in_stage.y >>> SHIFT;
   assign dy = in_stage.x >>> SHIFT;

   // A zero y counts as non-negative and rotates clockwise.
   always_comb begin
      if (in_stage.y[XY_W-1]) begin
         stage_in.x   = in_stage.x - dx;
         stage_in.y   = in_stage.y + dy;
         stage_in.acc = in_stage.acc + ATAN_STEP;
      end else begin
         stage_in.x   = in_stage.x + dx;
         stage_in.y   = in_stage.y - dy;
         stage_in.acc = in_stage.acc - ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

[hdl/cordic_cart_to_polar.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cordic_cart_to_polar
// Pipelined CORDIC vectoring: Cartesian point in, magnitude and phase out.
// ----------------------------------------------------------------------------
//  Channel   Ports                                  Handshake
//  request   req_x_coord, req_y_coord               start & !busy
//  response  rsp_magnitude, rsp_phase               rsp_valid, one-cycle strobe
//
// A transaction is taken every clock cycle; busy is held low.
// The pipeline has one quadrant stage, one stage per micro-rotation, one
// gain-multiply stage and one rounding stage.
// Reset clears only the valid bits of the pipeline; no result is lost or
// repeated since the receiver cannot stall and the pipeline never stops.
module cordic_cart_to_polar #(
   parameter int ITERATIONS = cc2p_pkg::DEF_ITERATIONS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [cc2p_pkg::COORD_W-1:0] req_x_coord,
   input  logic signed [cc2p_pkg::COORD_W-1:0] req_y_coord,
   output logic                              rsp_valid,
   output logic        [cc2p_pkg::MAG_W-1:0]   rsp_magnitude,
   output logic signed [cc2p_pkg::PHASE_W-1:0] rsp_phase
);
   import cc2p_pkg::*;

   localparam int STAGES = (ITERATIONS < ATAN_ENTRIES) ? ITERATIONS : ATAN_ENTRIES;

   logic signed [XY_W-1:0] x_ext;
   logic signed [XY_W-1:0] y_ext;
   stage_type              pre_in;
   stage_type              pipe [STAGES+1];
   logic [STAGES:0]        pipe_valid;
   logic                   pre_valid_ff;
   stage_type              pre_ff;

   logic [XY_W-2:0]               x_pos;
   logic [MAG_PROD_W-1:0]         prod_in;
   logic [MAG_PROD_W-1:0]         prod_ff;
   logic signed [PH_W-1:0]        ph_shift;
   logic signed [PHASE_W-1:0]     phase_in;
   logic signed [PHASE_W-1:0]     phase_ff;
   logic                          mult_valid_ff;

   logic [MAG_PROD_W-1:0]         prod_rnd;
   logic [MAG_PROD_W-17:0]        mag_wide;
   logic [MAG_W-1:0]              mag_in;
   logic [MAG_W-1:0]              mag_out_ff;
   logic signed [PHASE_W-1:0]     phase_out_ff;
   logic                          out_valid_ff;

   assign busy = 1'b0;

   // Bring the point into the right half plane.
   assign x_ext = XY_W'(req_x_coord);
   assign y_ext = XY_W'(req_y_coord);

   always_comb begin
      if (!x_ext[XY_W-1]) begin
         pre_in.x   = x_ext;
         pre_in.y   = y_ext;
         pre_in.acc = '0;
      end else if (y_ext[XY_W-1] || (y_ext == '0)) begin
         pre_in.x   = -y_ext;
         pre_in.y   = x_ext;
         pre_in.acc = HALF_PI_Q24;
      end else begin
         pre_in.x   = y_ext;
         pre_in.y   = -x_ext;
         pre_in.acc = -HALF_PI_Q24;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else begin
         pre_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      pre_ff <= pre_in;
   end

   assign pipe[0]       = pre_ff;
   assign pipe_valid[0] = pre_valid_ff;

   for (genvar i = 0; i < STAGES; i++) begin : g_rot
      cc2p_micro_rot #(
         .SHIFT (i)
      ) u_rot (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (pipe_valid[i]),
         .in_stage  (pipe[i]),
         .out_valid (pipe_valid[i+1]),
         .out_stage (pipe[i+1])
      );
   end

   // Gain removal multiply; a negative final x counts as zero.
   assign x_pos   = pipe[STAGES].x[XY_W-1] ? '0 : pipe[STAGES].x[XY_W-2:0];
   assign prod_in = MAG_PROD_W'(x_pos) * MAG_PROD_W'(INV_GAIN_Q16);

   // Phase is the negated accumulator, rounded half up to 2^-16 and clamped.
   assign ph_shift = (PHASE_ROUND - PH_W'(pipe[STAGES].acc)) >>> 8;

   always_comb begin
      if (ph_shift > PHASE_LIMIT) begin
         phase_in = PHASE_W'(PHASE_LIMIT);
      end else if (ph_shift < -PHASE_LIMIT) begin
         phase_in = PHASE_W'(-PHASE_LIMIT);
      end else begin
         phase_in = ph_shift[PHASE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_valid_ff <= 1'b0;
      end else begin
         mult_valid_ff <= pipe_valid[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      phase_ff <= phase_in;
   end

   assign prod_rnd = prod_ff + MAG_ROUND;
   assign mag_wide = prod_rnd[MAG_PROD_W-1:16];
   assign mag_in   = (mag_wide > (MAG_PROD_W-16)'({MAG_W{1'b1}})) ? '1 : mag_wide[MAG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= mult_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      mag_out_ff   <= mag_in;
      phase_out_ff <= phase_ff;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_magnitude = mag_out_ff;
   assign rsp_phase     = phase_out_ff;

endmodule
